// ===== sv/decimated_moving_average_assert.svh =====
// ----------------------------------------------------------------------------
// decimated moving average assertion macros
// clocked on clk_i and held off while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef DECIMATED_MOVING_AVERAGE_ASSERT_SVH
`define DECIMATED_MOVING_AVERAGE_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define DMAVG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define DMAVG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/dmavg_pkg.sv =====
// ----------------------------------------------------------------------------
// dmavg_pkg
// shared constants, register codes and control structs of the
// decimated moving average
// ----------------------------------------------------------------------------
package dmavg_pkg;

  // default build sizes
  localparam int unsigned SAMPLE_BITS_DEF = 16;
  localparam int unsigned WINDOW_MAX_DEF  = 16;

  // fixed field widths
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned GROUP_W    = 16;
  localparam int unsigned WLEN_W     = 5;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GROUP_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN = 1'b1;

  // register reset values
  localparam logic [GROUP_W-1:0] GROUP_RST    = 16'd4;
  localparam int unsigned        WLEN_RST_INT = 16;

  // controller to datapath commands
  typedef struct packed {
    logic accept;     // take the sample beat, update the partial sum
    logic update;     // retire the partial sum into the ring
    logic div_start;  // load the divider with the running total
    logic load_out;   // move the quotient into the output register
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic group_done; // the beat being taken closes a group
    logic div_last;   // divider is on its last step
    logic out_free;   // output register can take a new result
  } status_t;

endpackage

// ===== sv/dmavg_stream_if.sv =====
// ----------------------------------------------------------------------------
// dmavg stream interfaces
// valid/ready channels for sample beats and result beats
// ----------------------------------------------------------------------------

// sample channel
interface dmavg_in_if #(
  parameter int unsigned SAMPLE_BITS = dmavg_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// result channel
interface dmavg_out_if;
  logic                               valid;
  logic                               ready;
  logic                               group_done;
  logic signed [dmavg_pkg::DATA_W-1:0] average;

  modport source (output valid, output group_done, output average, input ready);
  modport sink   (input valid, input group_done, input average, output ready);
endinterface

// ===== sv/dmavg_div.sv =====
// ----------------------------------------------------------------------------
// dmavg_div
// bit-serial restoring divider, signed dividend by unsigned divisor,
// quotient truncated toward zero, one quotient bit per cycle
// ----------------------------------------------------------------------------
module dmavg_div #(
  parameter int unsigned TOTAL_W = 37,
  parameter int unsigned LEN_W   = 5
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [TOTAL_W-1:0]           dividend_i,
  input  logic        [LEN_W-1:0]             divisor_i,
  output logic                                busy_o,
  output logic                                last_o,
  output logic signed [dmavg_pkg::DATA_W-1:0] quotient_o
);

  localparam int unsigned CNT_W = $clog2(TOTAL_W + 1);

  logic               busy_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [TOTAL_W-1:0] quo_q;
  logic [LEN_W-1:0]   rem_q;
  logic [LEN_W-1:0]   div_q;
  logic               neg_q;

  logic [LEN_W:0]     trial;
  logic [LEN_W:0]     diff;
  logic               ge;

  // one restoring step
  always_comb begin
    trial = {rem_q, quo_q[TOTAL_W-1]};
    diff  = trial - {1'b0, div_q};
    ge    = (trial >= {1'b0, div_q});
  end

  // step counter and busy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(TOTAL_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // magnitude shift register and partial remainder
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[TOTAL_W-1];
      quo_q <= dividend_i[TOTAL_W-1] ? (TOTAL_W'(0) - TOTAL_W'(dividend_i))
                                     : TOTAL_W'(dividend_i);
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
      quo_q <= {quo_q[TOTAL_W-2:0], ge};
    end
  end

  // sign restored on the low word
  always_comb begin
    if (neg_q) begin
      quotient_o = dmavg_pkg::DATA_W'(0) - quo_q[dmavg_pkg::DATA_W-1:0];
    end else begin
      quotient_o = quo_q[dmavg_pkg::DATA_W-1:0];
    end
  end

  assign busy_o = busy_q;
  assign last_o = busy_q && (cnt_q == CNT_W'(1));

endmodule

// ===== sv/dmavg_dp.sv =====
// ----------------------------------------------------------------------------
// dmavg_dp
// datapath: configuration registers, partial sum, ring memory with
// valid bits, running total, divider and output register
// ----------------------------------------------------------------------------
module dmavg_dp #(
  parameter int unsigned WINDOW_MAX  = dmavg_pkg::WINDOW_MAX_DEF,
  parameter int unsigned SAMPLE_BITS = dmavg_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [dmavg_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [dmavg_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic signed [SAMPLE_BITS-1:0]         sample_i,
  input  logic                                  out_ready_i,
  input  dmavg_pkg::cmd_t                       cmd_i,
  output dmavg_pkg::status_t                    status_o,
  output logic                                  out_valid_o,
  output logic                                  out_group_done_o,
  output logic signed [dmavg_pkg::DATA_W-1:0]   out_average_o
);

  localparam int unsigned DATA_W  = dmavg_pkg::DATA_W;
  localparam int unsigned GROUP_W = dmavg_pkg::GROUP_W;
  localparam int unsigned WLEN_W  = dmavg_pkg::WLEN_W;
  localparam int unsigned PTR_W   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int unsigned LEN_W   = $clog2(WINDOW_MAX + 1);
  localparam int unsigned TOTAL_W = DATA_W + $clog2(WINDOW_MAX) + 1;
  localparam int unsigned RST_LEN = (dmavg_pkg::WLEN_RST_INT > WINDOW_MAX) ?
                                    WINDOW_MAX : dmavg_pkg::WLEN_RST_INT;

  // effective window length of a written register value
  function automatic logic [LEN_W-1:0] eff_len(input logic [WLEN_W-1:0] v);
    logic [LEN_W-1:0] r;
    if (v == '0) begin
      r = LEN_W'(1);
    end else if (32'(v) > 32'(WINDOW_MAX)) begin
      r = LEN_W'(WINDOW_MAX);
    end else begin
      r = LEN_W'(v);
    end
    return r;
  endfunction

  logic [GROUP_W-1:0]        group_q;
  logic [LEN_W-1:0]          len_q;
  logic [PTR_W-1:0]          wp_q;
  logic [GROUP_W-1:0]        count_q;
  logic [DATA_W-1:0]         partial_q;
  logic signed [TOTAL_W-1:0] total_q;
  logic [WINDOW_MAX-1:0]     valid_q;
  logic [DATA_W-1:0]         rd_q;
  logic                      rd_valid_q;
  logic                      done_q;
  logic                      out_valid_q;
  logic                      out_done_q;
  logic [DATA_W-1:0]         out_avg_q;

  logic [DATA_W-1:0]         ring_mem [WINDOW_MAX];

  logic [GROUP_W-1:0]        count_next;
  logic [GROUP_W-1:0]        eff_group;
  logic                      closes;
  logic [LEN_W-1:0]          wp_plus;
  logic [PTR_W-1:0]          wp_next;
  logic [LEN_W-1:0]          len_new;
  logic [DATA_W-1:0]         sample_ext;
  logic signed [TOTAL_W-1:0] old_ext;
  logic signed [TOTAL_W-1:0] new_ext;
  logic signed [DATA_W-1:0]  quotient;
  logic                      div_busy;
  logic                      div_last;

  // group close decision and next ring slot
  always_comb begin
    count_next = count_q + GROUP_W'(1);
    eff_group  = (group_q == '0) ? GROUP_W'(1) : group_q;
    closes     = (count_next == '0) || (count_next >= eff_group);
    wp_plus    = LEN_W'(wp_q) + LEN_W'(1);
    wp_next    = (wp_plus == len_q) ? '0 : wp_plus[PTR_W-1:0];
    len_new    = eff_len(cfg_wdata_i[WLEN_W-1:0]);
    sample_ext = {{(DATA_W-SAMPLE_BITS){sample_i[SAMPLE_BITS-1]}}, sample_i};
    old_ext    = rd_valid_q ? TOTAL_W'(signed'(rd_q)) : '0;
    new_ext    = TOTAL_W'(signed'(partial_q));
  end

  // configuration, partial sum, ring bookkeeping and running total
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_q   <= dmavg_pkg::GROUP_RST;
      len_q     <= LEN_W'(RST_LEN);
      wp_q      <= PTR_W'(RST_LEN - 1);
      count_q   <= '0;
      partial_q <= '0;
      total_q   <= '0;
      valid_q   <= '0;
      done_q    <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dmavg_pkg::CFG_GROUP_SIZE: begin
          group_q <= cfg_wdata_i[GROUP_W-1:0];
        end
        dmavg_pkg::CFG_WINDOW_LEN: begin
          len_q   <= len_new;
          wp_q    <= PTR_W'(len_new - LEN_W'(1));
          total_q <= '0;
          valid_q <= '0;
        end
      endcase
    end else if (cmd_i.accept) begin
      partial_q <= partial_q + sample_ext;
      count_q   <= closes ? '0 : count_next;
      done_q    <= closes;
      if (closes) begin
        wp_q <= wp_next;
      end
    end else if (cmd_i.update) begin
      total_q       <= total_q - old_ext + new_ext;
      valid_q[wp_q] <= 1'b1;
      partial_q     <= '0;
    end
  end

  // ring memory, registered read of the slot about to be replaced
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      rd_q       <= ring_mem[wp_next];
      rd_valid_q <= valid_q[wp_next];
    end
    if (cmd_i.update) begin
      ring_mem[wp_q] <= partial_q;
    end
  end

  // average of the window
  dmavg_div #(
    .TOTAL_W (TOTAL_W),
    .LEN_W   (LEN_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (total_q),
    .divisor_i  (len_q),
    .busy_o     (div_busy),
    .last_o     (div_last),
    .quotient_o (quotient)
  );

  // output register valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_done_q <= done_q;
      out_avg_q  <= quotient;
    end
  end

  always_comb begin
    status_o.group_done = closes;
    status_o.div_last   = div_last && div_busy;
    status_o.out_free   = !out_valid_q || out_ready_i;
  end

  assign out_valid_o      = out_valid_q;
  assign out_group_done_o = out_done_q;
  assign out_average_o    = out_avg_q;

endmodule

// ===== sv/dmavg_ctrl.sv =====
// ----------------------------------------------------------------------------
// dmavg_ctrl
// controller: sequences accept, ring update, division and result load
// ----------------------------------------------------------------------------
module dmavg_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  dmavg_pkg::status_t status_i,
  output dmavg_pkg::cmd_t    cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_UPDATE = 5'b00010,
    ST_LOAD   = 5'b00100,
    ST_DIVIDE = 5'b01000,
    ST_FINISH = 5'b10000
  } state_e;

  state_e state_q;
  state_e state_d;

  // next state and commands
  always_comb begin
    state_d         = state_q;
    cmd_o.accept    = 1'b0;
    cmd_o.update    = 1'b0;
    cmd_o.div_start = 1'b0;
    cmd_o.load_out  = 1'b0;
    in_ready_o      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i) begin
          state_d = status_i.group_done ? ST_UPDATE : ST_LOAD;
        end
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = ST_LOAD;
      end
      ST_LOAD: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (status_i.div_last) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== sv/decimated_moving_average.sv =====
// ----------------------------------------------------------------------------
// decimated_moving_average
// Signed samples are summed in groups of group_size; each finished group
// sum replaces the oldest of window_len ring entries, and every sample
// beat yields one result beat carrying the group-close flag and the
// window mean truncated toward zero.
// Channels: in_i takes sample beats, out_o gives result beats, both
// valid/ready. cfg_we_i/cfg_idx_i/cfg_wdata_i write group_size (index 0)
// and window_len (index 1); a window_len write empties the ring.
// A sample moves from ST_IDLE through ST_UPDATE (only when it closes a
// group), ST_LOAD, ST_DIVIDE and ST_FINISH before its result is loaded.
// No new sample is taken until that result is loaded; the bit-serial
// divider takes one quotient bit per cycle over the running total.
// Reset empties the ring, loads group_size 4, window_len min(16, WINDOW_MAX);
// no clearing pass is needed, valid bits mark the written ring entries.
// A stalled receiver holds the result in the output register; the next
// sample is still taken and worked on, and waits only at the final load.
// ----------------------------------------------------------------------------
`include "decimated_moving_average_assert.svh"

module decimated_moving_average #(
  parameter int unsigned WINDOW_MAX  = dmavg_pkg::WINDOW_MAX_DEF,
  parameter int unsigned SAMPLE_BITS = dmavg_pkg::SAMPLE_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [dmavg_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [dmavg_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  dmavg_in_if.sink                         in_i,
  dmavg_out_if.source                      out_o
);

  dmavg_pkg::cmd_t    cmd;
  dmavg_pkg::status_t status;
  logic               in_ready;

  // controller
  dmavg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // datapath
  dmavg_dp #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .sample_i         (in_i.sample),
    .out_ready_i      (out_o.ready),
    .cmd_i            (cmd),
    .status_o         (status),
    .out_valid_o      (out_o.valid),
    .out_group_done_o (out_o.group_done),
    .out_average_o    (out_o.average)
  );

  assign in_i.ready = in_ready;

  // a taken sample beat blocks the next one until its result is loaded
  `DMAVG_ASSERT_NEXT(a_accept_blocks, in_i.valid && in_i.ready, !in_i.ready, "sample taken twice")
  // the output register is only loaded when it is free
  `DMAVG_ASSERT_NOW(a_load_free, cmd.load_out, status.out_free, "result overwritten")
  // a result beat appears only after a load
  `DMAVG_ASSERT_NOW(a_out_from_load, $rose(out_o.valid), $past(cmd.load_out), "valid without load")
  // no ring update, divider start or output load is issued while a sample is being taken
  `DMAVG_ASSERT_NOW(a_cmd_excl, cmd.accept, !(cmd.div_start || cmd.update || cmd.load_out), "cmd clash")

endmodule
